// ===== rtl/tcw_pkg.sv =====
package tcw_pkg;

    localparam int COL_OUT_W  = 7;
    localparam int ROW_OUT_W  = 5;
    localparam int OFS_OUT_W  = 11;
    localparam int CELL_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 2;

    localparam logic [APB_ADDR_W-1:0] ATTR_ADDR = '0;

    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_RETURN  = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] ATTR_RESET = 8'h07;

    typedef enum logic [1:0] {
        MODE_PUT   = 2'd0,
        MODE_CLEAR = 2'd1,
        MODE_SET   = 2'd2,
        MODE_READ  = 2'd3
    } mode_t;

endpackage

// ===== rtl/tcw_if.sv =====
interface tcw_cmd_if import tcw_pkg::*; ();
    logic              valid;
    logic              ready;
    mode_t             mode;
    logic [BYTE_W-1:0] char_code;
    logic [BYTE_W-1:0] col;
    logic [BYTE_W-1:0] row;

    modport source (output valid, mode, char_code, col, row, input ready);
    modport sink   (input valid, mode, char_code, col, row, output ready);
endinterface

interface tcw_rsp_if import tcw_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [COL_OUT_W-1:0] cursor_column;
    logic [ROW_OUT_W-1:0] cursor_line;
    logic [OFS_OUT_W-1:0] cursor_offset;
    logic [CELL_W-1:0]    cell_data;

    modport source (output valid, cursor_column, cursor_line, cursor_offset, cell_data,
                    input ready);
    modport sink   (input valid, cursor_column, cursor_line, cursor_offset, cell_data,
                    output ready);
endinterface

// ===== rtl/tcw_ram.sv =====
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/text_console_writer_core.sv =====
// channel  dir  handshake      word
// cmd      in   valid/ready    mode, char_code, col, row
// rsp      out  valid/ready    cursor_column, cursor_line, cursor_offset, cell_data
// apb      in   psel/penable   text_attribute at byte address 0
//
// put character, newline, carriage return, set cursor: result next cycle unless it scrolls
// read cell: result via the read state and the output register (one screen memory read)
// clear and scroll (put or newline past the last row): one screen memory write per cycle
// after reset the screen memory is blanked; cmd.ready stays low until it is done
// cmd.ready needs the idle state and a free or draining output register
module text_console_writer_core import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                  clk,
    input  logic                  rst_n,
    tcw_cmd_if.sink               cmd,
    tcw_rsp_if.source             rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);

    localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
    localparam logic [AW-1:0] IDX_LAST  = AW'(CELLS - 1);
    localparam logic [AW-1:0] SRC_END   = AW'(CELLS - COLUMNS);
    localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);
    localparam logic [BYTE_W-1:0] COL_LIM = BYTE_W'(COLUMNS);
    localparam logic [BYTE_W-1:0] ROW_LIM = BYTE_W'(ROWS);

    typedef enum logic [4:0] {
        S_INIT   = 5'b00001,
        S_IDLE   = 5'b00010,
        S_CLEAR  = 5'b00100,
        S_SCROLL = 5'b01000,
        S_READ   = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [CW-1:0]        col_reg, col_next;
    logic [RW-1:0]        row_reg, row_next;
    logic [BYTE_W-1:0]    attr_reg;
    logic [CELL_W-1:0]    blank_reg, blank_next;
    logic                 pend_reg, pend_next;
    logic [AW-1:0]        pend_addr_reg, pend_addr_next;
    logic                 pend_sel_reg, pend_sel_next;
    logic [CELL_W-1:0]    pend_data_reg, pend_data_next;
    logic                 fwd_reg, fwd_next;
    logic [CELL_W-1:0]    fwd_data_reg, fwd_data_next;
    logic                 out_valid_reg, out_valid_next;
    logic [COL_OUT_W-1:0] out_col_reg, out_col_next;
    logic [ROW_OUT_W-1:0] out_row_reg, out_row_next;
    logic [OFS_OUT_W-1:0] out_ofs_reg, out_ofs_next;
    logic [CELL_W-1:0]    out_cell_reg, out_cell_next;

    logic [CW-1:0]     sat_col;
    logic [RW-1:0]     sat_row;
    logic [AW-1:0]     cur_lin;
    logic [AW-1:0]     sel_lin;
    logic [AW-1:0]     ofs_next;
    logic [AW-1:0]     raddr;
    logic [CELL_W-1:0] ram_rdata;
    logic [CELL_W-1:0] wdata;
    logic              cmd_acc;
    logic              out_take;
    logic              cfg_wr;
    logic              emit;
    logic              adv;
    logic [CELL_W-1:0] emit_cell;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (pend_reg),
        .waddr (pend_addr_reg),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    assign wdata    = pend_sel_reg ? ram_rdata : pend_data_reg;
    assign cmd_acc  = cmd.valid && cmd.ready;
    assign out_take = rsp.valid && rsp.ready;
    assign cmd.ready = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);

    assign rsp.valid         = out_valid_reg;
    assign rsp.cursor_column = out_col_reg;
    assign rsp.cursor_line   = out_row_reg;
    assign rsp.cursor_offset = out_ofs_reg;
    assign rsp.cell_data     = out_cell_reg;

    // apb register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == ATTR_ADDR);
    assign prdata = APB_DATA_W'(attr_reg);

    // saturated coordinates and linear addresses
    assign sat_col  = (cmd.col >= COL_LIM) ? COL_LAST : cmd.col[CW-1:0];
    assign sat_row  = (cmd.row >= ROW_LIM) ? ROW_LAST : cmd.row[RW-1:0];
    assign cur_lin  = AW'(row_reg) * COLS_A + AW'(col_reg);
    assign sel_lin  = AW'(sat_row) * COLS_A + AW'(sat_col);
    assign ofs_next = AW'(row_next) * COLS_A + AW'(col_next);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        blank_next     = blank_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        pend_sel_next  = 1'b0;
        pend_data_next = pend_data_reg;
        fwd_next       = fwd_reg;
        fwd_data_next  = fwd_data_reg;
        raddr          = sel_lin;
        emit           = 1'b0;
        adv            = 1'b0;
        emit_cell      = '0;

        unique case (state_reg)
            S_INIT, S_CLEAR:
            begin
                pend_next      = 1'b1;
                pend_addr_next = idx_reg;
                pend_data_next = blank_reg;
                if (idx_reg == IDX_LAST)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                    emit       = (state_reg == S_CLEAR);
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_SCROLL:
            begin
                // copy from one row below, each cell is written in the cycle after its read
                raddr          = idx_reg + COLS_A;
                pend_next      = 1'b1;
                pend_addr_next = idx_reg;
                pend_sel_next  = (idx_reg < SRC_END);
                pend_data_next = blank_reg;
                if (idx_reg == IDX_LAST)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                    emit       = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_READ:
            begin
                emit       = 1'b1;
                emit_cell  = fwd_reg ? fwd_data_reg : ram_rdata;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (cmd_acc)
                begin
                    unique case (cmd.mode)
                        MODE_PUT:
                        begin
                            priority if (cmd.char_code == CH_NEWLINE)
                            begin
                                col_next = '0;
                                adv      = 1'b1;
                            end
                            else if (cmd.char_code == CH_RETURN)
                            begin
                                col_next = '0;
                                emit     = 1'b1;
                            end
                            else
                            begin
                                pend_next      = 1'b1;
                                pend_addr_next = cur_lin;
                                pend_data_next = {attr_reg, cmd.char_code};
                                if (col_reg == COL_LAST)
                                begin
                                    col_next = '0;
                                    adv      = 1'b1;
                                end
                                else
                                begin
                                    col_next = col_reg + 1'b1;
                                    emit     = 1'b1;
                                end
                            end
                        end
                        MODE_CLEAR:
                        begin
                            blank_next = {attr_reg, CH_SPACE};
                            col_next   = '0;
                            row_next   = '0;
                            idx_next   = '0;
                            state_next = S_CLEAR;
                        end
                        MODE_SET:
                        begin
                            col_next = sat_col;
                            row_next = sat_row;
                            emit     = 1'b1;
                        end
                        MODE_READ:
                        begin
                            // a pending write may still be in flight to the same cell
                            fwd_next      = pend_reg && (pend_addr_reg == sel_lin);
                            fwd_data_next = wdata;
                            state_next    = S_READ;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                    if (adv)
                    begin
                        if (row_reg == ROW_LAST)
                        begin
                            blank_next = {attr_reg, CH_SPACE};
                            idx_next   = '0;
                            state_next = S_SCROLL;
                        end
                        else
                        begin
                            row_next = row_reg + 1'b1;
                            emit     = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_take;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        out_ofs_next   = out_ofs_reg;
        out_cell_next  = out_cell_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_col_next   = COL_OUT_W'(col_next);
            out_row_next   = ROW_OUT_W'(row_next);
            out_ofs_next   = OFS_OUT_W'(ofs_next);
            out_cell_next  = emit_cell;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            idx_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            attr_reg      <= ATTR_RESET;
            blank_reg     <= {ATTR_RESET, CH_SPACE};
            pend_reg      <= 1'b0;
            fwd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            blank_reg     <= blank_next;
            pend_reg      <= pend_next;
            fwd_reg       <= fwd_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr)
            begin
                attr_reg <= pwdata[BYTE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        pend_sel_reg  <= pend_sel_next;
        pend_data_reg <= pend_data_next;
        fwd_data_reg  <= fwd_data_next;
        out_col_reg   <= out_col_next;
        out_row_reg   <= out_row_next;
        out_ofs_reg   <= out_ofs_next;
        out_cell_reg  <= out_cell_next;
    end

    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ready |-> state_reg == S_IDLE)
        else $error("cmd.ready outside idle state");

    a_read_waits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_acc && cmd.mode == MODE_READ |=> state_reg == S_READ)
        else $error("read cell did not enter memory read state");

    a_clear_homes: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> col_reg == '0 && row_reg == '0)
        else $error("cursor not homed during clear");

    a_init_silent: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_INIT |-> !out_valid_reg && !fwd_reg)
        else $error("result produced during reset blanking");

endmodule
